[src/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/olist_pkg.sv]
package olist_pkg;

   // list depth and derived widths
   localparam int CAPACITY  = 64;
   localparam int VAL_W     = 32;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   // fixed field widths of the beats
   localparam int CMD_W     = 3;
   localparam int POS_W     = 7;
   localparam int FPOS_W    = 6;
   localparam int ECNT_W    = 7;
   localparam int STAT_W    = 2;

   // common width for position against count compares
   localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

   // match scan groups
   localparam int GRP       = 8;
   localparam int OFF_W     = $clog2(GRP);
   localparam int GROUPS    = (CAPACITY + GRP - 1) / GRP;
   localparam int GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int MATCH_W   = GROUPS * GRP;

   localparam logic signed [VAL_W-1:0] FAIL_VALUE = -32'sd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_HEAD = 3'd0,
      CMD_INS_TAIL = 3'd1,
      CMD_INS_AT   = 3'd2,
      CMD_RM_HEAD  = 3'd3,
      CMD_RM_TAIL  = 3'd4,
      CMD_RM_AT    = 3'd5,
      CMD_RM_VALUE = 3'd6,
      CMD_SEARCH   = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_NONE  = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                  command;
      logic signed [VAL_W-1:0]  item_value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [VAL_W-1:0]  removed_value;
      logic [FPOS_W-1:0]        found_position;
      logic [ECNT_W-1:0]        entry_count;
   } rsp_type;

   // what a cell loads on the next edge
   typedef enum logic [1:0] {
      ACT_HOLD  = 2'd0,
      ACT_LEFT  = 2'd1,
      ACT_RIGHT = 2'd2,
      ACT_LOAD  = 2'd3
   } cell_act_type;

   typedef struct packed {
      cell_act_type act;
      logic         cmp_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic              valid;
      logic [VAL_W-1:0]  value;
   } cell_data_type;

endpackage

[src/olist_cell.sv]
module olist_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  olist_pkg::cell_ctrl_type ctrl,
   input  logic [olist_pkg::VAL_W-1:0] key,
   input  olist_pkg::cell_data_type left_in,
   input  olist_pkg::cell_data_type right_in,
   output olist_pkg::cell_data_type data_out,
   output logic                    match_out
);

   logic                        valid_ff, valid_in;
   logic [olist_pkg::VAL_W-1:0] value_ff, value_in;
   logic                        match_ff, match_in;

   // pick the next entry: hold, shift from a neighbor or load the key
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (ctrl.act)
         olist_pkg::ACT_LEFT: begin
            valid_in = left_in.valid;
            value_in = left_in.value;
         end
         olist_pkg::ACT_RIGHT: begin
            valid_in = right_in.valid;
            value_in = right_in.value;
         end
         olist_pkg::ACT_LOAD: begin
            valid_in = 1'b1;
            value_in = key;
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   // compare against the key on request, otherwise hold the flag
   assign match_in = ctrl.cmp_en ? (valid_ff && (value_ff == key)) : match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign data_out.valid = valid_ff;
   assign data_out.value = value_ff;
   assign match_out      = match_ff;

endmodule

[src/olist_scan.sv]
module olist_scan (
   input  logic [olist_pkg::MATCH_W-1:0]   match_vec,
   input  logic [olist_pkg::GRP_IDX_W-1:0] grp,
   output logic                            hit,
   output logic [olist_pkg::OFF_W-1:0]     offset
);

   logic [olist_pkg::GRP-1:0] slice;

   // take one group of match flags
   assign slice = match_vec[grp * olist_pkg::GRP +: olist_pkg::GRP];
   assign hit   = |slice;

   // lowest set flag wins
   always_comb begin
      offset = '0;
      for (int i = olist_pkg::GRP - 1; i >= 0; i--) begin
         if (slice[i]) begin
            offset = olist_pkg::OFF_W'(i);
         end
      end
   end

endmodule

[src/ordered_list_engine.sv]
// Insert and remove by head, tail or position go from the accepted beat through
// the apply state to the registered result beat; search and remove-by-value first
// pass the match and scan states, the scan walking the cell flags 8 cells per cycle.
// Commands are taken only in the idle state, so a new one waits until the last result is registered.
// Reset (synchronous) clears the count and every cell valid bit.
module ordered_list_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  olist_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output olist_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_SCAN  = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   olist_pkg::req_type                req_ff, req_in;
   logic [olist_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [olist_pkg::GRP_IDX_W-1:0]   grp_ff, grp_in;
   logic                              hit_ff, hit_in;
   logic [olist_pkg::IDX_W-1:0]       hit_pos_ff, hit_pos_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   olist_pkg::rsp_type                rsp_ff, rsp_in;

   olist_pkg::cell_ctrl_type          ctrl_w  [olist_pkg::CAPACITY];
   olist_pkg::cell_data_type          cell_w  [olist_pkg::CAPACITY];
   logic [olist_pkg::CAPACITY-1:0]    match_w;
   logic [olist_pkg::MATCH_W-1:0]     match_pad;

   logic                              accept;
   logic                              out_free;
   logic                              commit;
   logic                              scan_hit;
   logic [olist_pkg::OFF_W-1:0]       scan_off;
   logic                              is_lookup;

   logic                              full;
   logic                              pos_past;
   logic                              do_ins;
   logic                              do_rm;
   logic [olist_pkg::IDX_W-1:0]       ins_idx;
   logic [olist_pkg::IDX_W-1:0]       rm_idx;
   logic [olist_pkg::VAL_W-1:0]       rm_val;
   olist_pkg::status_type             status_w;
   logic signed [olist_pkg::VAL_W-1:0] rv_w;

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == S_APPLY) && out_free;
   assign is_lookup = (req_data.command == olist_pkg::CMD_RM_VALUE) ||
                      (req_data.command == olist_pkg::CMD_SEARCH);

   // cell chain
   genvar gi;
   generate
      for (gi = 0; gi < olist_pkg::CAPACITY; gi++) begin : g_cell
         olist_pkg::cell_data_type left_w, right_w;

         if (gi == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_mid_l
            assign left_w = cell_w[gi-1];
         end
         if (gi == olist_pkg::CAPACITY - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_mid_r
            assign right_w = cell_w[gi+1];
         end

         // shift right above the insert point, left from the remove point up
         always_comb begin
            ctrl_w[gi].cmp_en = (state_ff == S_MATCH);
            ctrl_w[gi].act    = olist_pkg::ACT_HOLD;
            if (commit && do_ins) begin
               if (olist_pkg::IDX_W'(gi) > ins_idx) begin
                  ctrl_w[gi].act = olist_pkg::ACT_LEFT;
               end else if (olist_pkg::IDX_W'(gi) == ins_idx) begin
                  ctrl_w[gi].act = olist_pkg::ACT_LOAD;
               end
            end else if (commit && do_rm) begin
               if (olist_pkg::IDX_W'(gi) >= rm_idx) begin
                  ctrl_w[gi].act = olist_pkg::ACT_RIGHT;
               end
            end
         end

         olist_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl_w[gi]),
            .key       (req_ff.item_value),
            .left_in   (left_w),
            .right_in  (right_w),
            .data_out  (cell_w[gi]),
            .match_out (match_w[gi])
         );
      end
   endgenerate

   assign match_pad = olist_pkg::MATCH_W'(match_w);

   olist_scan u_scan (
      .match_vec (match_pad),
      .grp       (grp_ff),
      .hit       (scan_hit),
      .offset    (scan_off)
   );

   // decode the command against the current count
   always_comb begin
      full     = (count_ff >= olist_pkg::CNT_W'(olist_pkg::CAPACITY));
      pos_past = (olist_pkg::CMP_W'(req_ff.position) >= olist_pkg::CMP_W'(count_ff));
      do_ins   = 1'b0;
      do_rm    = 1'b0;
      ins_idx  = '0;
      rm_idx   = '0;
      status_w = olist_pkg::STAT_OK;
      rv_w     = '0;
      unique case (req_ff.command) inside
         olist_pkg::CMD_INS_HEAD, olist_pkg::CMD_INS_TAIL, olist_pkg::CMD_INS_AT: begin
            if (full) begin
               status_w = olist_pkg::STAT_FULL;
               rv_w     = olist_pkg::FAIL_VALUE;
            end else begin
               do_ins = 1'b1;
               if (req_ff.command == olist_pkg::CMD_INS_HEAD) begin
                  ins_idx = '0;
               end else if (req_ff.command == olist_pkg::CMD_INS_AT && !pos_past) begin
                  ins_idx = olist_pkg::IDX_W'(req_ff.position);
               end else begin
                  ins_idx = olist_pkg::IDX_W'(count_ff);
               end
            end
         end
         olist_pkg::CMD_RM_HEAD, olist_pkg::CMD_RM_TAIL: begin
            if (count_ff == '0) begin
               status_w = olist_pkg::STAT_NONE;
               rv_w     = olist_pkg::FAIL_VALUE;
            end else begin
               do_rm = 1'b1;
               if (req_ff.command == olist_pkg::CMD_RM_HEAD) begin
                  rm_idx = '0;
               end else begin
                  rm_idx = olist_pkg::IDX_W'(count_ff - olist_pkg::CNT_W'(1));
               end
               rv_w = rm_val;
            end
         end
         olist_pkg::CMD_RM_AT: begin
            if (pos_past) begin
               status_w = olist_pkg::STAT_RANGE;
               rv_w     = olist_pkg::FAIL_VALUE;
            end else begin
               do_rm  = 1'b1;
               rm_idx = olist_pkg::IDX_W'(req_ff.position);
               rv_w   = rm_val;
            end
         end
         olist_pkg::CMD_RM_VALUE, olist_pkg::CMD_SEARCH: begin
            if (hit_ff) begin
               do_rm  = (req_ff.command == olist_pkg::CMD_RM_VALUE);
               rm_idx = hit_pos_ff;
               rv_w   = req_ff.item_value;
            end else begin
               status_w = olist_pkg::STAT_NONE;
               rv_w     = olist_pkg::FAIL_VALUE;
            end
         end
         default: begin
            status_w = olist_pkg::STAT_NONE;
            rv_w     = olist_pkg::FAIL_VALUE;
         end
      endcase
   end

   // read the entry at the remove point
   always_comb begin
      rm_val = '0;
      for (int i = 0; i < olist_pkg::CAPACITY; i++) begin
         if (olist_pkg::IDX_W'(i) == rm_idx) begin
            rm_val = rm_val | cell_w[i].value;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      grp_in     = grp_ff;
      hit_in     = hit_ff;
      hit_pos_in = hit_pos_ff;
      count_in   = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               grp_in   = '0;
               state_in = is_lookup ? S_MATCH : S_APPLY;
            end
         end
         S_MATCH: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_hit) begin
               hit_in     = 1'b1;
               hit_pos_in = olist_pkg::IDX_W'({grp_ff, scan_off});
               state_in   = S_APPLY;
            end else if (grp_ff == olist_pkg::GRP_IDX_W'(olist_pkg::GROUPS - 1)) begin
               hit_in   = 1'b0;
               state_in = S_APPLY;
            end else begin
               grp_in = grp_ff + olist_pkg::GRP_IDX_W'(1);
            end
         end
         S_APPLY: begin
            if (out_free) begin
               if (do_ins) begin
                  count_in = count_ff + olist_pkg::CNT_W'(1);
               end else if (do_rm) begin
                  count_in = count_ff - olist_pkg::CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (commit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = status_w;
         rsp_in.removed_value  = rv_w;
         rsp_in.found_position = (status_w == olist_pkg::STAT_OK && hit_ff &&
                                  (req_ff.command == olist_pkg::CMD_RM_VALUE ||
                                   req_ff.command == olist_pkg::CMD_SEARCH))
                                 ? olist_pkg::FPOS_W'(hit_pos_ff) : '0;
         rsp_in.entry_count    = olist_pkg::ECNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         grp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         grp_ff       <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      hit_pos_ff <= hit_pos_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/olist_checker.sv]
`include "assert_macros.svh"

module olist_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input olist_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input olist_pkg::rsp_type rsp_data
);

   logic any_req;

   // the request side takes part only in the accept check below
   assign any_req = req_valid || req_stall || (req_data.position != '0);

   // hold a stalled result beat
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result beat changed")

   // count never passes the capacity
   `ASSERT_IMPLY(a_count_max, clock, reset, rsp_valid, rsp_data.entry_count <= olist_pkg::CAPACITY, "entry count above capacity")

   // a failed command reports the fail value
   `ASSERT_IMPLY(a_fail_value, clock, reset, rsp_valid && (rsp_data.status != olist_pkg::STAT_OK), rsp_data.removed_value == olist_pkg::FAIL_VALUE, "failed command without fail value")

   // full is reported only with a full list
   `ASSERT_IMPLY(a_full_count, clock, reset, rsp_valid && (rsp_data.status == olist_pkg::STAT_FULL), rsp_data.entry_count == olist_pkg::CAPACITY, "full status below capacity")

   // an accepted beat never coexists with a stalled request side
   `ASSERT_IMPLY(a_req_quiet, clock, reset, any_req && req_valid && !req_stall, !req_stall, "request accept while stalled")

endmodule

bind ordered_list_engine olist_checker u_checker (.*);
